FILE: rtl/core/jrl_pkg.sv
// Shared types and constants for the jerk-limited ramp unit.
package jrl_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int LIMIT_WIDTH = 15;
    localparam int STEP_WIDTH  = (VALUE_WIDTH > LIMIT_WIDTH + 1) ? VALUE_WIDTH : LIMIT_WIDTH + 1;
    localparam int CALC_WIDTH  = STEP_WIDTH + 3;
    localparam int INDEX_WIDTH = 2;

    localparam logic [LIMIT_WIDTH-1:0] ACCEL_RESET = LIMIT_WIDTH'(70);
    localparam logic [LIMIT_WIDTH-1:0] DECEL_RESET = LIMIT_WIDTH'(45);
    localparam logic [LIMIT_WIDTH-1:0] JERK_RESET  = LIMIT_WIDTH'(2);

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_ACCEL = 2'd0,
        REG_DECEL = 2'd1,
        REG_JERK  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] accel;
        logic [LIMIT_WIDTH-1:0] decel;
        logic [LIMIT_WIDTH-1:0] jerk;
    } limits_t;

endpackage

FILE: rtl/core/jrl_cfg.sv
// Configuration registers holding the accel, decel and jerk limits.
module jrl_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [jrl_pkg::INDEX_WIDTH-1:0]     cfg_index,
    input  logic [jrl_pkg::LIMIT_WIDTH-1:0]     cfg_data,
    output jrl_pkg::limits_t                    limits
);

    jrl_pkg::limits_t limits_reg;
    jrl_pkg::limits_t limits_next;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            unique case (jrl_pkg::reg_index_t'(cfg_index))
                jrl_pkg::REG_ACCEL: limits_next.accel = cfg_data;
                jrl_pkg::REG_DECEL: limits_next.decel = cfg_data;
                jrl_pkg::REG_JERK:  limits_next.jerk  = cfg_data;
                default:            limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.accel <= jrl_pkg::ACCEL_RESET;
            limits_reg.decel <= jrl_pkg::DECEL_RESET;
            limits_reg.jerk  <= jrl_pkg::JERK_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

FILE: rtl/core/jrl_step.sv
// Combinational next-state logic for one ramp tick.
module jrl_step (
    input  jrl_pkg::limits_t                        limits,
    input  logic                                    stop,
    input  logic signed [jrl_pkg::VALUE_WIDTH-1:0]  target,
    input  logic signed [jrl_pkg::VALUE_WIDTH-1:0]  cur_value,
    input  logic signed [jrl_pkg::STEP_WIDTH-1:0]   cur_step,
    output logic signed [jrl_pkg::VALUE_WIDTH-1:0]  new_value,
    output logic signed [jrl_pkg::STEP_WIDTH-1:0]   new_step,
    output logic                                    at_target
);

    logic signed [jrl_pkg::CALC_WIDTH-1:0] cur_x;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] tgt_x;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] stp_x;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] err;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] lim_x;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] jerk_x;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] want;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] adj;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] flo;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] clp;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] abs_err;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] abs_flo;
    logic signed [jrl_pkg::CALC_WIDTH-1:0] sum;
    logic [jrl_pkg::LIMIT_WIDTH-1:0]       lim_sel;
    logic [jrl_pkg::LIMIT_WIDTH-1:0]       jerk_sel;
    logic                                  err_pos;
    logic                                  away;
    logic                                  reversing;
    logic [jrl_pkg::VALUE_WIDTH-1:0]       sum_low;

    always_comb
    begin
        cur_x = {{(jrl_pkg::CALC_WIDTH - jrl_pkg::VALUE_WIDTH){cur_value[jrl_pkg::VALUE_WIDTH-1]}},
                 cur_value};
        tgt_x = {{(jrl_pkg::CALC_WIDTH - jrl_pkg::VALUE_WIDTH){target[jrl_pkg::VALUE_WIDTH-1]}},
                 target};
        stp_x = {{(jrl_pkg::CALC_WIDTH - jrl_pkg::STEP_WIDTH){cur_step[jrl_pkg::STEP_WIDTH-1]}},
                 cur_step};
        err     = tgt_x - cur_x;
        err_pos = (err > 0);
        away    = err_pos ? (cur_x >= 0) : (cur_x <= 0);

        lim_sel  = away ? limits.accel : limits.decel;
        if (lim_sel == '0)
        begin
            lim_sel = jrl_pkg::LIMIT_WIDTH'(1);
        end
        jerk_sel = (limits.jerk == '0) ? jrl_pkg::LIMIT_WIDTH'(1) : limits.jerk;
        lim_x    = {{(jrl_pkg::CALC_WIDTH - jrl_pkg::LIMIT_WIDTH){1'b0}}, lim_sel};
        jerk_x   = {{(jrl_pkg::CALC_WIDTH - jrl_pkg::LIMIT_WIDTH){1'b0}}, jerk_sel};
        want     = err_pos ? lim_x : -lim_x;

        reversing = ((stp_x > 0) && (want < 0)) || ((stp_x < 0) && (want > 0));

        adj = stp_x;
        if (reversing)
        begin
            adj = '0;
        end
        else if (stp_x < want)
        begin
            adj = stp_x + jerk_x;
            if (adj > want)
            begin
                adj = want;
            end
        end
        else if (stp_x > want)
        begin
            adj = stp_x - jerk_x;
            if (adj < want)
            begin
                adj = want;
            end
        end

        flo = adj;
        if (!reversing && err_pos && (adj <= 0))
        begin
            flo = jrl_pkg::CALC_WIDTH'(1);
        end
        else if (!reversing && (err < 0) && (adj >= 0))
        begin
            flo = -jrl_pkg::CALC_WIDTH'(1);
        end

        abs_err = (err < 0) ? -err : err;
        abs_flo = (flo < 0) ? -flo : flo;
        clp     = (abs_err < abs_flo) ? err : flo;

        sum     = cur_x + clp;
        sum_low = sum[jrl_pkg::VALUE_WIDTH-1:0];

        if (stop)
        begin
            new_value = '0;
            new_step  = '0;
        end
        else if (err == 0)
        begin
            new_value = cur_value;
            new_step  = '0;
        end
        else
        begin
            new_value = sum_low;
            new_step  = (sum == tgt_x) ? '0 : clp[jrl_pkg::STEP_WIDTH-1:0];
        end

        at_target = (new_value == target);
    end

endmodule

FILE: rtl/core/jerk_limited_ramp_unit.sv
// Top level of the jerk-limited ramp unit: input and result registers around one tick.
//
// Usage: each beat on the input channel (in_valid/in_ready, fields mode and
// target) is one control tick. Mode 0 moves the held value toward target by a
// step that changes by at most the jerk limit per tick but drops to zero on a
// reversal; it is capped by the remaining distance, by the accel limit when
// moving away from zero and by the decel limit otherwise. Mode 1 is an
// emergency stop that clears the value and the step. Every input beat gives
// exactly one result beat on the output channel (out_valid/out_ready,
// fields value and at_target). A beat passes the input register, then the
// result register. One beat per cycle is sustained while out_ready stays high;
// the tick logic between the two registers is a single add, compare and clamp
// pass. The limits are written through cfg_we, cfg_index and cfg_data while idle.
// Reset clears the held value and step, empties both registers and loads the
// limits 70, 45 and 2. When the receiver stalls, the result register holds its
// beat, one more beat waits in the input register, then in_ready drops.
module jerk_limited_ramp_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    mode,
    input  logic signed [jrl_pkg::VALUE_WIDTH-1:0]  target,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [jrl_pkg::VALUE_WIDTH-1:0]  value,
    output logic                                    at_target,
    input  logic                                    cfg_we,
    input  logic [jrl_pkg::INDEX_WIDTH-1:0]         cfg_index,
    input  logic [jrl_pkg::LIMIT_WIDTH-1:0]         cfg_data
);

    jrl_pkg::limits_t                        limits;
    logic                                    in_valid_reg;
    logic                                    mode_reg;
    logic signed [jrl_pkg::VALUE_WIDTH-1:0]  target_reg;
    logic                                    out_valid_reg;
    logic signed [jrl_pkg::VALUE_WIDTH-1:0]  value_reg;
    logic                                    at_target_reg;
    logic signed [jrl_pkg::VALUE_WIDTH-1:0]  ramp_value_reg;
    logic signed [jrl_pkg::STEP_WIDTH-1:0]   ramp_step_reg;
    logic signed [jrl_pkg::VALUE_WIDTH-1:0]  ramp_value_next;
    logic signed [jrl_pkg::STEP_WIDTH-1:0]   ramp_step_next;
    logic                                    at_target_next;
    logic                                    advance;
    logic                                    take;

    jrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    jrl_step u_step (
        .limits    (limits),
        .stop      (mode_reg),
        .target    (target_reg),
        .cur_value (ramp_value_reg),
        .cur_step  (ramp_step_reg),
        .new_value (ramp_value_next),
        .new_step  (ramp_step_next),
        .at_target (at_target_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ramp_value_reg <= '0;
            ramp_step_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                ramp_value_reg <= ramp_value_next;
                ramp_step_reg  <= ramp_step_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg   <= mode;
            target_reg <= target;
        end
        if (advance)
        begin
            value_reg     <= ramp_value_next;
            at_target_reg <= at_target_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign at_target = at_target_reg;

endmodule
